// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file agc_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define AGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define AGC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/agc_pkg.sv =====
package agc_pkg;

  // Grid geometry: 4096 x 4096 cells, one color bit each, 32 cells per row word
  localparam int GRID_SIDE = 4096;
  localparam int CW        = $clog2(GRID_SIDE);
  localparam int ROW_CELLS = 32;
  localparam int CELL_BITS = $clog2(ROW_CELLS);
  localparam int ROW_AW    = 2 * CW - CELL_BITS;
  localparam int GRID_ROWS = GRID_SIDE * GRID_SIDE / ROW_CELLS;
  localparam logic [CW-1:0] CENTRE = CW'(GRID_SIDE / 2);

  // Run limits
  localparam int MAX_CAP     = 1048576;
  localparam int STEP_W      = 21;
  localparam int PAT_W       = 25;
  localparam int TOUCH_DEPTH = MAX_CAP + PAT_W;
  localparam int TOUCH_AW    = $clog2(TOUCH_DEPTH);

  // Highway detection constants
  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PERIOD     = 104;
  localparam int MARGIN     = 20;
  localparam int NPER       = 20;
  localparam int CERT_SPAN  = 2184;
  localparam int DISP_W     = 8;

  // Result codes
  localparam logic [1:0] ST_CERT  = 2'd0;
  localparam logic [1:0] ST_CAP   = 2'd1;
  localparam logic [1:0] ST_EDGE  = 2'd2;
  localparam logic [1:0] ST_STILL = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_BOX    = 2'd0;
  localparam logic [1:0] REG_CAP    = 2'd1;
  localparam logic [1:0] REG_STRICT = 2'd2;

  typedef struct packed {
    logic [CW-1:0] x_lo;
    logic [CW-1:0] y_lo;
    logic [CW-1:0] x_hi;
    logic [CW-1:0] y_hi;
  } bbox_t;

  typedef struct packed {
    logic          turn;
    bbox_t         box;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [1:0]    head;
  } ring_entry_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_AW-1:0]    rd_row;
    logic                 wr_en;
    logic [ROW_AW-1:0]    wr_row;
    logic [ROW_CELLS-1:0] wr_word;
    logic                 tw_en;
    logic [TOUCH_AW-1:0]  tw_addr;
    logic [ROW_AW-1:0]    tw_row;
    logic                 tr_en;
    logic [TOUCH_AW-1:0]  tr_addr;
  } grid_req_t;

  typedef struct packed {
    logic acc;
    logic first;
  } scan_ctl_t;

endpackage

// ===== hdl/agc_grid.sv =====
module agc_grid (
  input  logic                               clk,
  input  agc_pkg::grid_req_t                 req,
  output logic [agc_pkg::ROW_CELLS-1:0]      rd_word,
  output logic [agc_pkg::ROW_AW-1:0]         touch_row
);

  logic [agc_pkg::ROW_CELLS-1:0] cells   [0:agc_pkg::GRID_ROWS-1];
  logic [agc_pkg::ROW_AW-1:0]    touched [0:agc_pkg::TOUCH_DEPTH-1];

  // Cell grid, 32 cells per word, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) cells[req.wr_row] <= req.wr_word;
    if (req.rd_en) rd_word <= cells[req.rd_row];
  end

  // Rows touched during a run, replayed to clear the grid
  always_ff @(posedge clk) begin
    if (req.tw_en) touched[req.tw_addr] <= req.tw_row;
    if (req.tr_en) touch_row <= touched[req.tr_addr];
  end

endmodule

// ===== hdl/agc_ring.sv =====
module agc_ring (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [agc_pkg::RING_AW-1:0]   wr_addr,
  input  agc_pkg::ring_entry_t          wr_data,
  input  logic                          rd_en,
  input  logic [agc_pkg::RING_AW-1:0]   rd_addr,
  output agc_pkg::ring_entry_t          rd_data
);

  agc_pkg::ring_entry_t mem [0:agc_pkg::RING_DEPTH-1];

  // History of turn, box, position and heading per step
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/agc_scan.sv =====
module agc_scan (
  input  logic                                clk,
  input  agc_pkg::scan_ctl_t                  ctl,
  input  logic [agc_pkg::CW-1:0]              q_x,
  input  logic [agc_pkg::CW-1:0]              q_y,
  input  logic signed [agc_pkg::DISP_W-1:0]   dx,
  input  logic signed [agc_pkg::DISP_W-1:0]   dy,
  input  agc_pkg::bbox_t                      snap,
  output logic                                pt_ok,
  output logic                                all_ok,
  output logic                                foot_ok
);

  logic [agc_pkg::CW-1:0]     x_min, x_max, y_min, y_max;
  logic [agc_pkg::DISP_W-1:0] ax, ay;
  logic [agc_pkg::CW:0]       lim_x, lim_y;

  // Ahead of the box by the margin, on the side the ant travels to
  function automatic logic past_margin(input logic [agc_pkg::CW-1:0] q,
                                       input logic signed [agc_pkg::DISP_W-1:0] d,
                                       input logic [agc_pkg::CW-1:0] lo,
                                       input logic [agc_pkg::CW-1:0] hi);
    logic [agc_pkg::CW:0] qe;
    logic [agc_pkg::CW:0] m;
    qe = {1'b0, q};
    m  = (agc_pkg::CW+1)'(agc_pkg::MARGIN);
    if (d > 0) return qe >= ({1'b0, hi} + m);
    else return (qe + m) <= {1'b0, lo};
  endfunction

  assign pt_ok = past_margin(q_x, dx, snap.x_lo, snap.x_hi) &&
                 past_margin(q_y, dy, snap.y_lo, snap.y_hi);

  // Running margin flag and footprint over the streamed positions
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      if (ctl.first) begin
        all_ok <= pt_ok;
        x_min  <= q_x;
        x_max  <= q_x;
        y_min  <= q_y;
        y_max  <= q_y;
      end else begin
        all_ok <= all_ok & pt_ok;
        if (q_x < x_min) x_min <= q_x;
        if (q_x > x_max) x_max <= q_x;
        if (q_y < y_min) y_min <= q_y;
        if (q_y > y_max) y_max <= q_y;
      end
    end
  end

  // Footprint must stay under NPER periods of travel: 20 = 16 + 4
  assign ax = dx[agc_pkg::DISP_W-1] ? agc_pkg::DISP_W'(-dx) : agc_pkg::DISP_W'(dx);
  assign ay = dy[agc_pkg::DISP_W-1] ? agc_pkg::DISP_W'(-dy) : agc_pkg::DISP_W'(dy);
  assign lim_x = ((agc_pkg::CW+1)'(ax) << 4) + ((agc_pkg::CW+1)'(ax) << 2);
  assign lim_y = ((agc_pkg::CW+1)'(ay) << 4) + ((agc_pkg::CW+1)'(ay) << 2);
  assign foot_ok = ({1'b0, x_max - x_min} < lim_x) && ({1'b0, y_max - y_min} < lim_y);

endmodule

// ===== hdl/ant_highway_certifier.sv =====
// Langton's ant highway certifier. Pulse start while busy is low to run one
// pattern; busy stays high until the run and the grid clean-up are over. The
// single result appears for exactly one cycle with done high and must be
// captured then. Each ant step reads the grid word and the history, then
// does a read-modify-write with the history ring. Each step that has met the
// matching span adds a displacement step, then a margin check. A strict-mode
// check then also walks the 104-entry position history. Loading the pattern
// visits each box cell and writes each black cell. Clean-up replays the
// touched list, which holds one entry per step and one per black cell. The
// grid memory's single write port sets the per-step cost. After reset the
// block sweeps all 524288 grid rows to zero, one per cycle, with busy high.
// Configuration writes are taken at any time but are only allowed while busy
// is low.
module ant_highway_certifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [agc_pkg::PAT_W-1:0]           init_pattern,
  input  logic                                write_enable,
  input  logic [1:0]                          reg_index,
  input  logic [agc_pkg::STEP_W-1:0]          write_data,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [agc_pkg::STEP_W-1:0]          onset_step,
  output logic [agc_pkg::STEP_W-1:0]          steps_run,
  output logic signed [agc_pkg::DISP_W-1:0]   disp_x,
  output logic signed [agc_pkg::DISP_W-1:0]   disp_y,
  output logic signed [agc_pkg::CW-1:0]       final_x,
  output logic signed [agc_pkg::CW-1:0]       final_y,
  output logic signed [agc_pkg::CW-1:0]       box_x_low,
  output logic signed [agc_pkg::CW-1:0]       box_y_low,
  output logic signed [agc_pkg::CW-1:0]       box_x_high,
  output logic signed [agc_pkg::CW-1:0]       box_y_high,
  output logic [1:0]                          travel_dir
);

  typedef enum logic [11:0] {
    S_WIPE   = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_PAT    = 12'b0000_0000_0100,
    S_PAT_WR = 12'b0000_0000_1000,
    S_RD     = 12'b0000_0001_0000,
    S_EXEC   = 12'b0000_0010_0000,
    S_DISP   = 12'b0000_0100_0000,
    S_MARGIN = 12'b0000_1000_0000,
    S_SCAN   = 12'b0001_0000_0000,
    S_FOOT   = 12'b0010_0000_0000,
    S_FINISH = 12'b0100_0000_0000,
    S_CLEAR  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [2:0]                    box_size;
  logic [agc_pkg::STEP_W-1:0]    step_cap;
  logic                          strict_mode;

  // Run state
  logic [agc_pkg::STEP_W-1:0]    cap;
  logic [agc_pkg::PAT_W-1:0]     pat_sh;
  logic [2:0]                    col, row;
  logic [agc_pkg::CW-1:0]        ant_x, ant_y;
  logic [1:0]                    head;
  logic [agc_pkg::STEP_W-1:0]    step_count, last_mismatch;
  agc_pkg::bbox_t                live, snap;
  logic signed [agc_pkg::DISP_W-1:0] dx, dy;
  logic [agc_pkg::TOUCH_AW-1:0]  tcount, clr_idx;
  logic                          clr_pend;
  logic                          edge_hit, certified;
  logic [agc_pkg::RING_AW-1:0]   scan_idx;
  logic [agc_pkg::ROW_AW-1:0]    wipe_row;

  // Memory and unit connections
  agc_pkg::grid_req_t            greq;
  logic [agc_pkg::ROW_CELLS-1:0] word_q;
  logic [agc_pkg::ROW_AW-1:0]    touch_row;
  logic                          ring_we, ring_re;
  logic [agc_pkg::RING_AW-1:0]   ring_waddr, ring_raddr;
  agc_pkg::ring_entry_t          ring_wdata, ring_q;
  agc_pkg::scan_ctl_t            sctl;
  logic [agc_pkg::CW-1:0]        sq_x, sq_y;
  logic                          pt_ok, all_ok, foot_ok;

  // Step datapath
  logic [agc_pkg::STEP_W-1:0]    n_now;
  logic [agc_pkg::CW-1:0]        base, cx, cy, pt_x, pt_y, x_nx, y_nx;
  agc_pkg::bbox_t                live_nx;
  logic                          cell_bit, turn, mism, cert_nx, edge_nx, pat_done;
  logic [1:0]                    head_nx;
  logic [agc_pkg::ROW_CELLS-1:0] cell_mask;
  logic [agc_pkg::CW:0]          dx_full, dy_full;
  logic                          clr_issue;

  agc_grid u_grid (
    .clk       (clk),
    .req       (greq),
    .rd_word   (word_q),
    .touch_row (touch_row)
  );

  agc_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_q)
  );

  agc_scan u_scan (
    .clk     (clk),
    .ctl     (sctl),
    .q_x     (sq_x),
    .q_y     (sq_y),
    .dx      (dx),
    .dy      (dy),
    .snap    (snap),
    .pt_ok   (pt_ok),
    .all_ok  (all_ok),
    .foot_ok (foot_ok)
  );

  assign busy = (state != S_IDLE);

  // Pattern cell position and point that widens the box
  assign base     = agc_pkg::CENTRE - agc_pkg::CW'(box_size >> 1);
  assign cx       = base + agc_pkg::CW'(col);
  assign cy       = base + agc_pkg::CW'(row);
  assign pat_done = (box_size == 3'd0) || (row == box_size);
  assign pt_x     = (state == S_PAT_WR) ? cx : ant_x;
  assign pt_y     = (state == S_PAT_WR) ? cy : ant_y;

  always_comb begin
    live_nx = live;
    if (pt_x < live.x_lo) live_nx.x_lo = pt_x;
    if (pt_x > live.x_hi) live_nx.x_hi = pt_x;
    if (pt_y < live.y_lo) live_nx.y_lo = pt_y;
    if (pt_y > live.y_hi) live_nx.y_hi = pt_y;
  end

  // Turn, flip and move
  assign n_now     = step_count + agc_pkg::STEP_W'(1);
  assign cell_mask = agc_pkg::ROW_CELLS'(1) << pt_x[agc_pkg::CELL_BITS-1:0];
  assign cell_bit  = |(word_q & cell_mask);
  assign turn      = ~cell_bit;
  assign head_nx   = cell_bit ? head + 2'd3 : head + 2'd1;

  always_comb begin
    x_nx = ant_x;
    y_nx = ant_y;
    unique case (head_nx)
      2'd0: y_nx = ant_y + agc_pkg::CW'(1);
      2'd1: x_nx = ant_x + agc_pkg::CW'(1);
      2'd2: y_nx = ant_y - agc_pkg::CW'(1);
      2'd3: x_nx = ant_x - agc_pkg::CW'(1);
      default: x_nx = ant_x;
    endcase
  end

  assign edge_nx = (x_nx == '0) || (x_nx == '1) || (y_nx == '0) || (y_nx == '1);
  assign mism    = (n_now > agc_pkg::STEP_W'(agc_pkg::PERIOD)) && (ring_q.turn != turn);
  assign cert_nx = !mism &&
                   (n_now >= last_mismatch + agc_pkg::STEP_W'(agc_pkg::CERT_SPAN));

  assign dx_full = {1'b0, ant_x} - {1'b0, ring_q.px};
  assign dy_full = {1'b0, ant_y} - {1'b0, ring_q.py};
  assign clr_issue = (clr_idx < tcount);

  // Memory requests per state
  always_comb begin
    greq       = '0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_waddr = n_now[agc_pkg::RING_AW-1:0];
    ring_raddr = n_now[agc_pkg::RING_AW-1:0] +
                 agc_pkg::RING_AW'(agc_pkg::RING_DEPTH - agc_pkg::PERIOD);
    ring_wdata = '{turn: turn, box: live_nx, px: x_nx, py: y_nx, head: head_nx};
    sctl       = '0;
    sq_x       = ant_x;
    sq_y       = ant_y;
    greq.tw_addr = tcount;
    greq.tw_row  = {pt_y, pt_x[agc_pkg::CW-1:agc_pkg::CELL_BITS]};
    greq.wr_row  = {pt_y, pt_x[agc_pkg::CW-1:agc_pkg::CELL_BITS]};
    greq.rd_row  = {pt_y, pt_x[agc_pkg::CW-1:agc_pkg::CELL_BITS]};
    unique case (state)
      S_WIPE: begin
        greq.wr_en  = 1'b1;
        greq.wr_row = wipe_row;
      end
      S_PAT: begin
        greq.rd_en = !pat_done && pat_sh[0];
        greq.rd_row = {cy, cx[agc_pkg::CW-1:agc_pkg::CELL_BITS]};
      end
      S_PAT_WR: begin
        greq.wr_en   = 1'b1;
        greq.wr_word = word_q | cell_mask;
        greq.tw_en   = 1'b1;
      end
      S_RD: begin
        greq.rd_en = (step_count < cap);
        ring_re    = (step_count < cap);
      end
      S_EXEC: begin
        greq.wr_en   = 1'b1;
        greq.wr_word = word_q ^ cell_mask;
        greq.tw_en   = 1'b1;
        ring_we      = 1'b1;
      end
      S_SCAN: begin
        ring_re    = (scan_idx < agc_pkg::RING_AW'(agc_pkg::PERIOD));
        ring_raddr = step_count[agc_pkg::RING_AW-1:0] - scan_idx;
        sctl.acc   = (scan_idx != '0);
        sctl.first = (scan_idx == agc_pkg::RING_AW'(1));
        sq_x       = ring_q.px;
        sq_y       = ring_q.py;
      end
      S_CLEAR: begin
        greq.tr_en   = clr_issue;
        greq.tr_addr = clr_idx;
        greq.wr_en   = clr_pend;
        greq.wr_row  = touch_row;
      end
      default: greq.rd_en = 1'b0;
    endcase
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      box_size    <= 3'd1;
      step_cap    <= agc_pkg::STEP_W'(agc_pkg::MAX_CAP);
      strict_mode <= 1'b0;
    end else if (write_enable) begin
      case (reg_index)
        agc_pkg::REG_BOX:    box_size    <= write_data[2:0];
        agc_pkg::REG_CAP:    step_cap    <= write_data;
        agc_pkg::REG_STRICT: strict_mode <= write_data[0];
        default:             box_size    <= box_size;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WIPE;
      wipe_row <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_WIPE: begin
          wipe_row <= wipe_row + agc_pkg::ROW_AW'(1);
          if (&wipe_row) state <= S_IDLE;
        end
        S_IDLE: if (start) state <= S_PAT;
        S_PAT: begin
          if (pat_done) state <= S_RD;
          else if (pat_sh[0]) state <= S_PAT_WR;
        end
        S_PAT_WR: state <= S_PAT;
        S_RD: state <= (step_count < cap) ? S_EXEC : S_FINISH;
        S_EXEC: begin
          if (edge_nx) state <= S_FINISH;
          else if (cert_nx) state <= S_DISP;
          else state <= S_RD;
        end
        S_DISP: state <= S_MARGIN;
        S_MARGIN: begin
          if (dx != 0 && dy != 0 && pt_ok) begin
            if (!strict_mode) state <= S_FINISH;
            else if (ring_q.head != head) state <= S_RD;
            else state <= S_SCAN;
          end else begin
            state <= S_RD;
          end
        end
        S_SCAN: if (scan_idx == agc_pkg::RING_AW'(agc_pkg::PERIOD)) state <= S_FOOT;
        S_FOOT: state <= (all_ok && foot_ok) ? S_FINISH : S_RD;
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_CLEAR;
        end
        S_CLEAR: if (!clr_issue && !clr_pend) state <= S_IDLE;
        default: state <= S_WIPE;
      endcase
    end
  end

  // Run datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cap           <= (step_cap > agc_pkg::STEP_W'(agc_pkg::MAX_CAP)) ?
                         agc_pkg::STEP_W'(agc_pkg::MAX_CAP) : step_cap;
        pat_sh        <= init_pattern;
        col           <= 3'd0;
        row           <= 3'd0;
        ant_x         <= agc_pkg::CENTRE;
        ant_y         <= agc_pkg::CENTRE;
        head          <= 2'd0;
        step_count    <= '0;
        last_mismatch <= '0;
        live          <= '{agc_pkg::CENTRE, agc_pkg::CENTRE,
                           agc_pkg::CENTRE, agc_pkg::CENTRE};
        dx            <= '0;
        dy            <= '0;
        tcount        <= '0;
        edge_hit      <= 1'b0;
        certified     <= 1'b0;
      end
      S_PAT: begin
        if (pat_done) begin
          snap <= live;
        end else if (!pat_sh[0]) begin
          pat_sh <= pat_sh >> 1;
          if (col == box_size - 3'd1) begin
            col <= 3'd0;
            row <= row + 3'd1;
          end else begin
            col <= col + 3'd1;
          end
        end
      end
      S_PAT_WR: begin
        live   <= live_nx;
        tcount <= tcount + agc_pkg::TOUCH_AW'(1);
        pat_sh <= pat_sh >> 1;
        if (col == box_size - 3'd1) begin
          col <= 3'd0;
          row <= row + 3'd1;
        end else begin
          col <= col + 3'd1;
        end
      end
      S_EXEC: begin
        step_count <= n_now;
        tcount     <= tcount + agc_pkg::TOUCH_AW'(1);
        live       <= live_nx;
        head       <= head_nx;
        ant_x      <= x_nx;
        ant_y      <= y_nx;
        edge_hit   <= edge_nx;
        if (!edge_nx && mism) begin
          last_mismatch <= n_now - agc_pkg::STEP_W'(agc_pkg::PERIOD);
          snap          <= ring_q.box;
        end
      end
      S_DISP: begin
        dx <= agc_pkg::DISP_W'(dx_full);
        dy <= agc_pkg::DISP_W'(dy_full);
        scan_idx <= '0;
      end
      S_MARGIN: begin
        scan_idx <= '0;
        if (dx != 0 && dy != 0 && pt_ok && !strict_mode) certified <= 1'b1;
      end
      S_SCAN: scan_idx <= scan_idx + agc_pkg::RING_AW'(1);
      S_FOOT: if (all_ok && foot_ok) certified <= 1'b1;
      S_FINISH: begin
        clr_idx  <= '0;
        clr_pend <= 1'b0;
      end
      S_CLEAR: begin
        clr_pend <= clr_issue;
        if (clr_issue) clr_idx <= clr_idx + agc_pkg::TOUCH_AW'(1);
      end
      default: clr_pend <= 1'b0;
    endcase
  end

  // Result registers, loaded as the result is shown
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      priority if (certified) status <= agc_pkg::ST_CERT;
      else if (edge_hit) status <= agc_pkg::ST_EDGE;
      else if ((step_count >= last_mismatch + agc_pkg::STEP_W'(agc_pkg::CERT_SPAN)) &&
               (dx == 0 || dy == 0)) status <= agc_pkg::ST_STILL;
      else status <= agc_pkg::ST_CAP;
      onset_step <= last_mismatch;
      steps_run  <= step_count;
      disp_x     <= dx;
      disp_y     <= dy;
      final_x    <= {~ant_x[agc_pkg::CW-1], ant_x[agc_pkg::CW-2:0]};
      final_y    <= {~ant_y[agc_pkg::CW-1], ant_y[agc_pkg::CW-2:0]};
      box_x_low  <= {~snap.x_lo[agc_pkg::CW-1], snap.x_lo[agc_pkg::CW-2:0]};
      box_y_low  <= {~snap.y_lo[agc_pkg::CW-1], snap.y_lo[agc_pkg::CW-2:0]};
      box_x_high <= {~snap.x_hi[agc_pkg::CW-1], snap.x_hi[agc_pkg::CW-2:0]};
      box_y_high <= {~snap.y_hi[agc_pkg::CW-1], snap.y_hi[agc_pkg::CW-2:0]};
      travel_dir <= {!(dx > 0), !(dy > 0)};
    end
  end

endmodule

// ===== hdl/agc_check.sv =====
`include "assert_macros.svh"

module agc_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [1:0]                         status,
  input logic [agc_pkg::STEP_W-1:0]         steps_run,
  input logic signed [agc_pkg::CW-1:0]      final_x,
  input logic signed [agc_pkg::CW-1:0]      final_y
);

  // An accepted request keeps the block busy
  `AGC_ASSERT_NXT(a_req_busy, start && !busy, busy)

  // Results only come while a run is in progress
  `AGC_ASSERT_IMP(a_done_busy, done, busy)

  // One result per run: never two strobes back to back
  `AGC_ASSERT_NXT(a_done_single, done, !done)

  // A certified run has seen the full matching span
  `AGC_ASSERT_IMP(a_cert_span, done && status == agc_pkg::ST_CERT, steps_run >= agc_pkg::STEP_W'(agc_pkg::CERT_SPAN))

  // A boundary stop leaves the ant on the outermost row or column
  `AGC_ASSERT_IMP(a_edge_pos, done && status == agc_pkg::ST_EDGE, (final_x == 12'sh800 || final_x == 12'sh7FF || final_y == 12'sh800 || final_y == 12'sh7FF))

endmodule

bind ant_highway_certifier agc_check u_agc_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .steps_run (steps_run),
  .final_x   (final_x),
  .final_y   (final_y)
);
